/* rtl/clb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and constants for the cursor line edit buffer.
// ----------------------------------------------------------------------------
package clb_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] KEY_HOME   = 8'h2D;  // '-'
  localparam logic [7:0] KEY_END    = 8'h2B;  // '+'
  localparam logic [7:0] KEY_RIGHT  = 8'h2A;  // '*'
  localparam logic [7:0] KEY_DELETE = 8'h33;  // '3'

  typedef enum logic [2:0] {
    OP_HOME,
    OP_END,
    OP_RIGHT,
    OP_DELETE,
    OP_INSERT
  } op_e;

  typedef enum logic {
    BACK_EDIT,
    BACK_EMIT
  } back_state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic       eol;
  } q_entry_t;

endpackage

/* rtl/clb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_front
// Accepts key words and classifies each one into an edit operation.
// ----------------------------------------------------------------------------
module clb_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        key_code_i,
  input  logic              end_of_line_i,
  output logic              push_o,
  output clb_pkg::q_entry_t entry_o,
  input  logic              full_i
);
  import clb_pkg::*;

  op_e op;

  always_comb begin
    case (key_code_i)
      KEY_HOME:   op = OP_HOME;
      KEY_END:    op = OP_END;
      KEY_RIGHT:  op = OP_RIGHT;
      KEY_DELETE: op = OP_DELETE;
      default:    op = OP_INSERT;
    endcase
  end

  assign in_stall_o    = full_i;
  assign push_o        = in_valid_i && !full_i;
  assign entry_o.op    = op;
  assign entry_o.ch    = key_code_i;
  assign entry_o.eol   = end_of_line_i;

endmodule

/* rtl/clb_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_fifo
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module clb_fifo #(
  parameter int Depth = clb_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  clb_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output clb_pkg::q_entry_t entry_o
);
  import clb_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/clb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_back
// Row of character cells with cursor; applies edits and emits the line.
// ----------------------------------------------------------------------------
module clb_back #(
  parameter int LineCapacity = clb_pkg::LINE_CAPACITY,
  localparam int LenW        = $clog2(LineCapacity + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  clb_pkg::q_entry_t entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_char_o,
  output logic              last_char_o,
  output logic              line_empty_o,
  output logic              overflowed_o,
  output logic [LenW-1:0]   cursor_o,
  output logic [LenW-1:0]   length_o
);
  import clb_pkg::*;

  back_state_e     state_q, state_d;
  logic [LenW-1:0] len_q, len_d, cur_q, cur_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      cell_q [LineCapacity];
  logic [7:0]      cell_d [LineCapacity];

  // Cell row controls: a right shift opens a slot at the cursor, a left
  // shift closes the slot at thr.
  logic            shift_ins, shift_del;
  logic [LenW-1:0] thr;
  logic            out_take;

  assign out_take = out_valid_o && !out_stall_i;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cur_d       = cur_q;
    ovf_d       = ovf_q;
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    shift_ins   = 1'b0;
    shift_del   = 1'b0;
    thr         = cur_q;
    case (state_q)
      BACK_EDIT: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (entry_i.op)
            OP_HOME:  cur_d = '0;
            OP_END:   cur_d = len_q;
            OP_RIGHT: begin
              if (cur_q < len_q) begin
                cur_d = cur_q + 1'b1;
              end
            end
            OP_DELETE: begin
              if (cur_q < len_q) begin
                shift_del = 1'b1;
                len_d     = len_q - 1'b1;
              end
            end
            default: begin
              if (len_q == LenW'(LineCapacity)) begin
                ovf_d = 1'b1;
              end else begin
                shift_ins = 1'b1;
                len_d     = len_q + 1'b1;
                cur_d     = cur_q + 1'b1;
              end
            end
          endcase
          if (entry_i.eol) begin
            state_d = BACK_EDIT == BACK_EDIT ? BACK_EMIT : BACK_EMIT;
          end
        end
      end
      BACK_EMIT: begin
        out_valid_o = 1'b1;
        thr         = '0;
        // The cursor has no use while the line drains, so it is parked at
        // zero and never runs past the shrinking length.
        cur_d       = '0;
        if (out_take) begin
          if (len_q <= LenW'(1)) begin
            state_d = BACK_EDIT;
            len_d   = '0;
            ovf_d   = 1'b0;
          end else begin
            // Emit by shifting the row toward cell zero.
            shift_del = 1'b1;
            len_d     = len_q - 1'b1;
          end
        end
      end
      default: state_d = BACK_EDIT;
    endcase
  end

  for (genvar g = 0; g < LineCapacity; g++) begin : g_cell
    logic [7:0] from_left, from_right;
    if (g == 0) begin : g_first
      assign from_left = entry_i.ch;
    end else begin : g_mid
      assign from_left = (LenW'(g) == cur_q) ? entry_i.ch : cell_q[g-1];
    end
    if (g == LineCapacity - 1) begin : g_last
      assign from_right = 8'h00;
    end else begin : g_inner
      assign from_right = cell_q[g+1];
    end
    always_comb begin
      cell_d[g] = cell_q[g];
      if (shift_ins && (LenW'(g) >= cur_q)) begin
        cell_d[g] = from_left;
      end else if (shift_del && (LenW'(g) >= thr)) begin
        cell_d[g] = from_right;
      end
    end
    always_ff @(posedge clk_i) begin
      cell_q[g] <= cell_d[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_EDIT;
      len_q   <= '0;
      cur_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      ovf_q   <= ovf_d;
    end
  end

  assign line_empty_o = (len_q == '0);
  assign out_char_o   = line_empty_o ? 8'h00 : cell_q[0];
  assign last_char_o  = (len_q <= LenW'(1));
  assign overflowed_o = ovf_q;
  assign cursor_o     = cur_q;
  assign length_o     = len_q;

endmodule

/* rtl/cursor_line_edit_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer
// Line edit buffer with cursor: classify front, operation queue, cell row.
// ----------------------------------------------------------------------------
// Each accepted word is queued and later applied to the cell row; no word is
// popped while a line drains, so the queue fills. End of line starts emission.
// Throughput: one word per cycle while the queue has room; a line of n
// characters drains as max(n,1) results, one per cycle unless stalled.
// Reset: asynchronous, clears queue pointers, length, cursor and overflow flag.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer #(
  parameter int LineCapacity = clb_pkg::LINE_CAPACITY,
  parameter int QueueDepth   = clb_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_code_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o,
  output logic       line_empty_o,
  output logic       overflowed_o
);
  import clb_pkg::*;

  localparam int LenW = $clog2(LineCapacity + 1);

  logic            push, full, pop, empty;
  q_entry_t        push_entry, head_entry;
  logic [LenW-1:0] cursor, length;

  clb_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_code_i    (key_code_i),
    .end_of_line_i (end_of_line_i),
    .push_o        (push),
    .entry_o       (push_entry),
    .full_i        (full)
  );

  clb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  clb_back #(
    .LineCapacity (LineCapacity)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o),
    .line_empty_o (line_empty_o),
    .overflowed_o (overflowed_o),
    .cursor_o     (cursor),
    .length_o     (length)
  );

  // No edit is applied while a line is draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !pop)
    else $error("queue popped during emission");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cursor <= length)
    else $error("cursor beyond line length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (length <= LenW'(LineCapacity)))
    else $error("line length beyond capacity");

  // The final word of a line ends emission and leaves a clean buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_char_o) |=>
      (!out_valid_o && !overflowed_o && (cursor == '0)))
    else $error("buffer not cleared after line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_empty_o) |-> last_char_o)
    else $error("empty line result not marked last");

endmodule

/* bench/cursor_line_edit_buffer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_tb
// Self-checking bench for the cursor line edit buffer. A queue of keystroke
// words feeds a clocked driver, and a clocked monitor checks every emitted
// character against an in-bench line editor that tracks store, cursor and
// overflow flag. Both sides idle at random. Once, the receiver stalls for a
// long stretch so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_tb;

  import clb_pkg::*;

  localparam int ClkHalf      = 10;
  localparam int ResetCycles  = 11;
  localparam int RandomItems  = 460;
  localparam int IdleLimit    = 2000;
  localparam int HoldAtResult = 60;
  localparam int HoldCycles   = 300;
  localparam int DrainCycles  = 20;

  localparam int LINE_SHORT = 0;
  localparam int LINE_LONG  = 1;
  localparam int LINE_WIPE  = 2;

  typedef struct {
    logic [7:0] key;
    logic       eol;
  } key_word_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       empty;
    logic       ovf;
  } line_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [7:0] key_code = 8'h00;
  logic       end_of_line = 1'b0;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic [7:0] out_char_o;
  logic       last_char_o;
  logic       line_empty_o;
  logic       overflowed_o;

  key_word_t  key_queue[$];
  line_char_t line_char_queue[$];

  // Editor state mirrored in the bench.
  logic [7:0] line_chars [LINE_CAPACITY];
  int         line_len;
  int         cursor;
  logic       ovf_seen;

  int fail_count;
  int random_count;
  int send_gap;
  int recv_gap;
  int hold_left;
  int results_seen;
  int idle_cycles;
  bit calm_send;
  bit calm_recv;

  cursor_line_edit_buffer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .key_code_i    (key_code),
    .end_of_line_i (end_of_line),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .out_char_o    (out_char_o),
    .last_char_o   (last_char_o),
    .line_empty_o  (line_empty_o),
    .overflowed_o  (overflowed_o)
  );

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  function automatic op_e classify_key(input logic [7:0] key);
    case (key)
      KEY_HOME:   return OP_HOME;
      KEY_END:    return OP_END;
      KEY_RIGHT:  return OP_RIGHT;
      KEY_DELETE: return OP_DELETE;
      default:    return OP_INSERT;
    endcase
  endfunction

  function automatic void clear_line();
    for (int i = 0; i < LINE_CAPACITY; i++) line_chars[i] = 8'h00;
    line_len = 0;
    cursor   = 0;
    ovf_seen = 1'b0;
  endfunction

  // Applies one keystroke and queues the characters an end of line emits.
  function automatic void apply_keystroke(input logic [7:0] key, input logic eol);
    line_char_t c;
    case (classify_key(key))
      OP_HOME:  cursor = 0;
      OP_END:   cursor = line_len;
      OP_RIGHT: begin
        if (cursor < line_len) cursor++;
      end
      OP_DELETE: begin
        if (cursor < line_len) begin
          for (int i = cursor; i + 1 < line_len; i++) line_chars[i] = line_chars[i + 1];
          line_len--;
          line_chars[line_len] = 8'h00;
        end
      end
      default: begin
        if (line_len >= LINE_CAPACITY) begin
          ovf_seen = 1'b1;
        end else begin
          for (int i = line_len; i > cursor; i--) line_chars[i] = line_chars[i - 1];
          line_chars[cursor] = key;
          line_len++;
          cursor++;
        end
      end
    endcase
    if (eol) begin
      if (line_len == 0) begin
        c = '{ch: 8'h00, last: 1'b1, empty: 1'b1, ovf: ovf_seen};
        line_char_queue = {line_char_queue, c};
      end else begin
        for (int i = 0; i < line_len; i++) begin
          c = '{ch: line_chars[i], last: (i + 1 == line_len), empty: 1'b0, ovf: ovf_seen};
          line_char_queue = {line_char_queue, c};
        end
      end
      clear_line();
    end
  endfunction

  function automatic void push_key(input logic [7:0] key, input logic eol);
    key_word_t w;
    w = '{key: key, eol: eol};
    key_queue = {key_queue, w};
  endfunction

  function automatic logic [7:0] random_key(input int insert_pct);
    if ($urandom_range(0, 99) < insert_pct) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return KEY_HOME;
      1:       return KEY_END;
      2:       return KEY_RIGHT;
      default: return KEY_DELETE;
    endcase
  endfunction

  function automatic logic [7:0] random_printable();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (classify_key(ch) != OP_INSERT);
    return ch;
  endfunction

  function automatic void add_random_line(input int kind);
    int n;
    if (kind == LINE_WIPE) begin
      // Overflow the store, then delete everything so the empty line
      // still carries the overflow flag.
      for (int k = 0; k < LINE_CAPACITY + 2; k++) push_key(random_printable(), 1'b0);
      push_key(KEY_HOME, 1'b0);
      for (int k = 0; k < LINE_CAPACITY; k++) push_key(KEY_DELETE, k == LINE_CAPACITY - 1);
      random_count += 2 * LINE_CAPACITY + 3;
    end else begin
      n = (kind == LINE_LONG) ? $urandom_range(LINE_CAPACITY - 2, LINE_CAPACITY + 8)
                              : $urandom_range(1, 12);
      for (int k = 0; k < n; k++) begin
        push_key(random_key((kind == LINE_LONG) ? 85 : 55), k == n - 1);
      end
      random_count += n;
    end
  endfunction

  // Sender: one word per item, with a random gap before each.
  always @(posedge clk_i or negedge rst_ni) begin
    key_word_t w;
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      key_code    <= 8'h00;
      end_of_line <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) apply_keystroke(key_code, end_of_line);
      if (!in_valid || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (key_queue.size() > 0) begin
          w = key_queue.pop_front();
          key_code    <= w.key;
          end_of_line <= w.eol;
          in_valid    <= 1'b1;
          if ($urandom_range(0, 31) == 0) calm_send = !calm_send;
          send_gap = calm_send ? 0 : $urandom_range(0, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word and draws its stall for the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    line_char_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (line_char_queue.size() == 0) begin
          $error("unexpected word: out_char %0h", out_char_o);
          fail_count++;
        end else begin
          e = line_char_queue.pop_front();
          if (out_char_o !== e.ch) begin
            $error("out_char: expected %0h, got %0h", e.ch, out_char_o);
            fail_count++;
          end
          if (last_char_o !== e.last) begin
            $error("last_char: expected %0b, got %0b", e.last, last_char_o);
            fail_count++;
          end
          if (line_empty_o !== e.empty) begin
            $error("line_empty: expected %0b, got %0b", e.empty, line_empty_o);
            fail_count++;
          end
          if (overflowed_o !== e.ovf) begin
            $error("overflowed: expected %0b, got %0b", e.ovf, overflowed_o);
            fail_count++;
          end
        end
        results_seen++;
        if (results_seen == HoldAtResult) hold_left = HoldCycles;
        if ($urandom_range(0, 31) == 0) calm_recv = !calm_recv;
        recv_gap = calm_recv ? 0 : $urandom_range(0, 12);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int line_no;
    fail_count   = 0;
    random_count = 0;
    send_gap     = 0;
    recv_gap     = 0;
    hold_left    = 0;
    results_seen = 0;
    idle_cycles  = 0;
    calm_send    = 1'b0;
    calm_recv    = 1'b0;
    clear_line();

    // Empty lines, one ended by a delete on nothing.
    push_key(KEY_HOME, 1'b1);
    push_key(KEY_DELETE, 1'b1);
    // Byte extremes, moves past the end and a delete at the end.
    push_key(8'h00, 1'b0);
    push_key(8'hFF, 1'b0);
    push_key(KEY_HOME, 1'b0);
    push_key(8'h55, 1'b0);
    push_key(8'hAA, 1'b0);
    push_key(KEY_RIGHT, 1'b0);
    push_key(KEY_RIGHT, 1'b0);
    push_key(KEY_RIGHT, 1'b0);
    push_key(KEY_DELETE, 1'b0);
    push_key(KEY_HOME, 1'b0);
    push_key(KEY_DELETE, 1'b0);
    push_key(KEY_END, 1'b0);
    push_key(8'h7F, 1'b1);
    // End of line on a right move.
    push_key(8'h78, 1'b0);
    push_key(KEY_HOME, 1'b0);
    push_key(KEY_RIGHT, 1'b1);
    // The closing delete leaves the line empty.
    push_key(8'h31, 1'b0);
    push_key(KEY_HOME, 1'b0);
    push_key(KEY_DELETE, 1'b1);
    push_key(8'h80, 1'b1);

    line_no = 0;
    while (random_count < RandomItems) begin
      if (line_no == 0) add_random_line(LINE_LONG);
      else if (line_no == 1) add_random_line(LINE_WIPE);
      else if ($urandom_range(0, 9) == 0) add_random_line(LINE_LONG);
      else add_random_line(LINE_SHORT);
      line_no++;
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (key_queue.size() > 0 || in_valid || line_char_queue.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (line_char_queue.size() > 0) begin
      $error("%0d expected words never arrived", line_char_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/clb_pkg.sv
rtl/clb_front.sv
rtl/clb_fifo.sv
rtl/clb_back.sv
rtl/cursor_line_edit_buffer.sv
bench/cursor_line_edit_buffer_tb.sv
